[hw/rtl/jh8_pkg.sv]
// ----------------------------------------------------------------------------
// jh8_pkg: shared types and constants of the joint histogram block
// Request kinds, field widths and the control bundle of a counter bank.
// ----------------------------------------------------------------------------
package jh8_pkg;

  // Request kinds carried in tuser.
  localparam logic [1:0] KIND_ACC    = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_SIGNED_A = 1'b0;
  localparam logic CFG_SIGNED_B = 1'b1;

  // Fixed field widths.
  localparam int PIX_W     = 8;
  localparam int LEVEL_W   = 9;
  localparam int OUT_CNT_W = 32;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 120;

  // A signed byte maps to its bin by flipping the sign bit (offset 128).
  localparam logic [PIX_W-1:0]   SIGN_FLIP     = 8'h80;
  localparam logic [LEVEL_W-1:0] SIGNED_OFFSET = 9'd128;

  // Control of one counter bank for one cycle.
  typedef struct packed {
    logic rd_en;   // capture the entry at the read address
    logic inc_en;  // write back the captured count plus one
    logic clr_en;  // write zero at the clear address
  } bank_ctl_t;

endpackage

[hw/rtl/jh8_count_bank.sv]
// ----------------------------------------------------------------------------
// jh8_count_bank: saturating counter memory
// A synchronous single-write memory of counters. A read captures an entry and
// its address; an increment in a later cycle writes the captured count plus
// one back to that address, unless the count is already at its maximum.
// ----------------------------------------------------------------------------
module jh8_count_bank #(
  parameter int ADDR_W     = 8,
  parameter int COUNT_BITS = 32
) (
  input  logic                    clk_i,
  input  jh8_pkg::bank_ctl_t      ctl_i,
  input  logic [ADDR_W-1:0]       rd_addr_i,
  input  logic [ADDR_W-1:0]       clr_addr_i,
  output logic [COUNT_BITS-1:0]   rd_data_o
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [COUNT_BITS-1:0] data_q;
  logic [ADDR_W-1:0]     addr_q;
  logic                  sat;

  assign sat       = (data_q == {COUNT_BITS{1'b1}});
  assign rd_data_o = data_q;

  // Registered read; the address is held for the write-back.
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      data_q <= mem[rd_addr_i];
      addr_q <= rd_addr_i;
    end
  end

  // One write port: clear sweep or saturating write-back.
  always_ff @(posedge clk_i) begin
    if (ctl_i.clr_en) begin
      mem[clr_addr_i] <= '0;
    end else if (ctl_i.inc_en && !sat) begin
      mem[addr_q] <= data_q + COUNT_BITS'(1);
    end
  end

endmodule

[hw/rtl/joint_histogram_8bit.sv]
// An accumulate request updates its counters in the cycle after it is
// accepted; a read result passes the bank read register and the result
// register before it shows on m_axis. A request is taken only in the idle
// state, not during a read, write-back or a clear request's clearing pass.
// Reset: the same clearing pass runs after reset, s_axis_tready stays low.
// ----------------------------------------------------------------------------
// joint_histogram_8bit: joint and marginal histograms of two 8-bit images
// Pixel pairs bump saturating counters held in three memories; read requests
// return the counts of one bin pair and their pixel levels.
// ----------------------------------------------------------------------------
module joint_histogram_8bit #(
  parameter int BINS       = 256,
  parameter int COUNT_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration write port.
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic         cfg_data_i,
  // Request stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pixel_a[7:0], pixel_a_valid[8], pixel_b[16:9], pixel_b_valid[17],
  // read_bin_a[25:18], read_bin_b[33:26], zero[39:34]
  input  logic [39:0]  s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]   s_axis_tuser,
  // Result stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // joint_count[31:0], marginal_a_count[63:32], marginal_b_count[95:64],
  // level_a[104:96], level_b[113:105], zero[119:114]
  output logic [119:0] m_axis_tdata
);

  localparam int BIN_W  = $clog2(BINS);
  localparam int JNT_W  = 2 * BIN_W;
  localparam int CMP_W  = ((BIN_W > 8) ? BIN_W : 8) + 1;
  localparam int PAD_W  = jh8_pkg::OUT_DATA_W - 3 * jh8_pkg::OUT_CNT_W
                          - 2 * jh8_pkg::LEVEL_W;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_READ   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [JNT_W-1:0] sweep_q, sweep_d;
  logic mode_a_q, mode_b_q;
  logic inc_a_q, inc_b_q, inc_j_q;
  logic ok_a_q, ok_b_q;
  logic [jh8_pkg::LEVEL_W-1:0] level_a_q, level_b_q;
  logic out_valid_q;
  logic [jh8_pkg::OUT_DATA_W-1:0] out_data_q;

  // Request fields.
  logic [1:0] kind;
  logic [jh8_pkg::PIX_W-1:0] pixel_a, pixel_b, read_bin_a, read_bin_b;
  logic pixel_a_valid, pixel_b_valid;

  assign kind          = s_axis_tuser;
  assign pixel_a       = s_axis_tdata[7:0];
  assign pixel_a_valid = s_axis_tdata[8];
  assign pixel_b       = s_axis_tdata[16:9];
  assign pixel_b_valid = s_axis_tdata[17];
  assign read_bin_a    = s_axis_tdata[25:18];
  assign read_bin_b    = s_axis_tdata[33:26];

  // Handshake: a request is taken only in the idle state and when the result register is free.
  logic in_ready, accept, is_acc, is_read, is_clear;
  assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign accept   = s_axis_tvalid && in_ready;
  assign is_acc   = accept && (kind == jh8_pkg::KIND_ACC);
  assign is_read  = accept && (kind == jh8_pkg::KIND_READ);
  assign is_clear = accept && (kind == jh8_pkg::KIND_CLEAR);
  assign s_axis_tready = in_ready;

  // Bin mapping and range checks.
  logic [jh8_pkg::PIX_W-1:0] bin_a8, bin_b8;
  logic in_a, in_b, ok_a, ok_b;
  assign bin_a8 = pixel_a ^ (jh8_pkg::SIGN_FLIP & {jh8_pkg::PIX_W{mode_a_q}});
  assign bin_b8 = pixel_b ^ (jh8_pkg::SIGN_FLIP & {jh8_pkg::PIX_W{mode_b_q}});
  assign in_a   = pixel_a_valid && (CMP_W'(bin_a8) < CMP_W'(BINS));
  assign in_b   = pixel_b_valid && (CMP_W'(bin_b8) < CMP_W'(BINS));
  assign ok_a   = CMP_W'(read_bin_a) < CMP_W'(BINS);
  assign ok_b   = CMP_W'(read_bin_b) < CMP_W'(BINS);

  // Bank addresses come from the pixels or from the read bins.
  logic [BIN_W-1:0] addr_a, addr_b;
  logic [JNT_W-1:0] addr_j;
  assign addr_a = is_read ? BIN_W'(read_bin_a) : BIN_W'(bin_a8);
  assign addr_b = is_read ? BIN_W'(read_bin_b) : BIN_W'(bin_b8);
  assign addr_j = {addr_a, addr_b};

  // Bank control.
  jh8_pkg::bank_ctl_t ctl_a, ctl_b, ctl_j;
  logic clearing, updating;
  assign clearing = (state_q == ST_CLEAR);
  assign updating = (state_q == ST_UPDATE);
  assign ctl_a = '{rd_en: is_acc || is_read, inc_en: updating && inc_a_q,
                   clr_en: clearing};
  assign ctl_b = '{rd_en: is_acc || is_read, inc_en: updating && inc_b_q,
                   clr_en: clearing};
  assign ctl_j = '{rd_en: is_acc || is_read, inc_en: updating && inc_j_q,
                   clr_en: clearing};

  logic [COUNT_BITS-1:0] cnt [3];

  jh8_count_bank #(.ADDR_W(JNT_W), .COUNT_BITS(COUNT_BITS)) u_joint (
    .clk_i      (clk_i),
    .ctl_i      (ctl_j),
    .rd_addr_i  (addr_j),
    .clr_addr_i (sweep_q),
    .rd_data_o  (cnt[0])
  );

  jh8_count_bank #(.ADDR_W(BIN_W), .COUNT_BITS(COUNT_BITS)) u_marg_a (
    .clk_i      (clk_i),
    .ctl_i      (ctl_a),
    .rd_addr_i  (addr_a),
    .clr_addr_i (sweep_q[BIN_W-1:0]),
    .rd_data_o  (cnt[1])
  );

  jh8_count_bank #(.ADDR_W(BIN_W), .COUNT_BITS(COUNT_BITS)) u_marg_b (
    .clk_i      (clk_i),
    .ctl_i      (ctl_b),
    .rd_addr_i  (addr_b),
    .clr_addr_i (sweep_q[BIN_W-1:0]),
    .rd_data_o  (cnt[2])
  );

  // Counts are clipped to the 32-bit result fields.
  logic [jh8_pkg::OUT_CNT_W-1:0] clip [3];
  for (genvar g = 0; g < 3; g++) begin : g_clip
    if (COUNT_BITS > jh8_pkg::OUT_CNT_W) begin : g_wide
      assign clip[g] = (|cnt[g][COUNT_BITS-1:jh8_pkg::OUT_CNT_W]) ?
                       {jh8_pkg::OUT_CNT_W{1'b1}} :
                       cnt[g][jh8_pkg::OUT_CNT_W-1:0];
    end else begin : g_narrow
      assign clip[g] = jh8_pkg::OUT_CNT_W'(cnt[g]);
    end
  end

  // Next state and clear sweep.
  always_comb begin
    state_d = state_q;
    sweep_d = sweep_q;
    case (state_q)
      ST_CLEAR: begin
        sweep_d = sweep_q + JNT_W'(1);
        if (sweep_q == {JNT_W{1'b1}}) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (is_acc) begin
          state_d = ST_UPDATE;
        end else if (is_read) begin
          state_d = ST_READ;
        end else if (is_clear) begin
          state_d = ST_CLEAR;
          sweep_d = '0;
        end
      end
      ST_UPDATE: state_d = ST_IDLE;
      ST_READ:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      sweep_q <= '0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_a_q <= 1'b0;
      mode_b_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == jh8_pkg::CFG_SIGNED_A) begin
        mode_a_q <= cfg_data_i;
      end else begin
        mode_b_q <= cfg_data_i;
      end
    end
  end

  // Per-request flags and levels held for the update or read state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_a_q <= 1'b0;
      inc_b_q <= 1'b0;
      inc_j_q <= 1'b0;
    end else if (accept) begin
      inc_a_q <= is_acc && in_a;
      inc_b_q <= is_acc && in_b;
      inc_j_q <= is_acc && in_a && in_b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_read) begin
      ok_a_q    <= ok_a;
      ok_b_q    <= ok_b;
      level_a_q <= {1'b0, read_bin_a} -
                   (jh8_pkg::SIGNED_OFFSET & {jh8_pkg::LEVEL_W{mode_a_q}});
      level_b_q <= {1'b0, read_bin_b} -
                   (jh8_pkg::SIGNED_OFFSET & {jh8_pkg::LEVEL_W{mode_b_q}});
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_READ) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      out_data_q <= {{PAD_W{1'b0}}, level_b_q, level_a_q,
                     ok_b_q ? clip[2] : '0,
                     ok_a_q ? clip[1] : '0,
                     (ok_a_q && ok_b_q) ? clip[0] : '0};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

[hw/rtl/jh8_checker.sv]
// ----------------------------------------------------------------------------
// jh8_checker: port-level checks of the joint histogram block
// Watches the request and result streams for ordering and timing slips.
// ----------------------------------------------------------------------------
module jh8_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [1:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [119:0] m_axis_tdata
);

  logic acc;
  logic rd_acc;
  assign acc    = s_axis_tvalid && s_axis_tready;
  assign rd_acc = acc && (s_axis_tuser == jh8_pkg::KIND_READ);

  // A stalled result holds its data.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  // Every read request produces a result on m_axis.
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_acc |=> ##1 m_axis_tvalid)
    else $error("read request gave no result");

  // A new result appears only for an earlier read request.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(rd_acc, 2))
    else $error("result without a read request");

  // A request that does work blocks the next cycle for its read, write-back or clearing pass.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (s_axis_tuser != jh8_pkg::KIND_UNUSED) |=> !s_axis_tready)
    else $error("request taken during a counter update");

endmodule

bind joint_histogram_8bit jh8_checker u_jh8_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for joint_histogram_8bit
// Streams accumulate, read, clear and unused requests through the block under
// random source gaps and sink stalls. Each read result is checked against a
// local model of the joint and marginal counters kept at the same widths.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int RANDOM_ITEMS = 370;
  localparam int N_PHASES     = 5;

  // One request as it travels on the slave stream.
  typedef struct packed {
    logic [1:0]                kind;
    logic [jh8_pkg::PIX_W-1:0] pix_a;
    logic                      va;
    logic [jh8_pkg::PIX_W-1:0] pix_b;
    logic                      vb;
    logic [jh8_pkg::PIX_W-1:0] rd_a;
    logic [jh8_pkg::PIX_W-1:0] rd_b;
  } pixel_req_t;

  // One read result as it travels on the master stream.
  typedef struct packed {
    logic [jh8_pkg::OUT_CNT_W-1:0] joint;
    logic [jh8_pkg::OUT_CNT_W-1:0] marg_a;
    logic [jh8_pkg::OUT_CNT_W-1:0] marg_b;
    logic [jh8_pkg::LEVEL_W-1:0]   lvl_a;
    logic [jh8_pkg::LEVEL_W-1:0]   lvl_b;
  } bin_report_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we_i = 1'b0;
  logic          cfg_idx_i = 1'b0;
  logic          cfg_data_i = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [39:0]   s_axis_tdata = '0;
  logic [1:0]    s_axis_tuser = jh8_pkg::KIND_UNUSED;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [119:0]  m_axis_tdata;

  joint_histogram_8bit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Requests waiting to be driven, and read results waiting to come back.
  pixel_req_t  pixel_requests[$];
  bin_report_t bin_reports_due[$];

  // Local copy of the counters and of the signed mode registers.
  logic [jh8_pkg::OUT_CNT_W-1:0] joint_cnt [65536];
  logic [jh8_pkg::OUT_CNT_W-1:0] marg_a_cnt [256];
  logic [jh8_pkg::OUT_CNT_W-1:0] marg_b_cnt [256];
  logic                          sgn_a = 1'b0;
  logic                          sgn_b = 1'b0;

  int errors = 0;
  int n_acc = 0, n_read = 0, n_clear = 0, n_unused = 0, n_checked = 0;
  int cycle_count = 0;

  // Signed mode settings per phase; the generator maps hot pixels with them.
  logic phase_sgn_a [N_PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
  logic phase_sgn_b [N_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
  logic       gen_sgn_a, gen_sgn_b;
  logic [7:0] hot_base;

  function automatic logic [jh8_pkg::OUT_CNT_W-1:0] sat_plus_one(
      logic [jh8_pkg::OUT_CNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic void clear_counts();
    foreach (joint_cnt[i]) joint_cnt[i] = '0;
    foreach (marg_a_cnt[i]) begin
      marg_a_cnt[i] = '0;
      marg_b_cnt[i] = '0;
    end
  endfunction

  // Apply one accepted request to the local counters; a read yields a report.
  task automatic histogram_update(pixel_req_t r);
    logic [7:0]  ba, bb;
    bin_report_t rep;
    case (r.kind)
      jh8_pkg::KIND_ACC: begin
        n_acc++;
        ba = r.pix_a ^ (sgn_a ? jh8_pkg::SIGN_FLIP : 8'h00);
        bb = r.pix_b ^ (sgn_b ? jh8_pkg::SIGN_FLIP : 8'h00);
        if (r.va) marg_a_cnt[ba] = sat_plus_one(marg_a_cnt[ba]);
        if (r.vb) marg_b_cnt[bb] = sat_plus_one(marg_b_cnt[bb]);
        if (r.va && r.vb) joint_cnt[{ba, bb}] = sat_plus_one(joint_cnt[{ba, bb}]);
      end
      jh8_pkg::KIND_READ: begin
        n_read++;
        rep.joint  = joint_cnt[{r.rd_a, r.rd_b}];
        rep.marg_a = marg_a_cnt[r.rd_a];
        rep.marg_b = marg_b_cnt[r.rd_b];
        rep.lvl_a  = {1'b0, r.rd_a} - (sgn_a ? jh8_pkg::SIGNED_OFFSET : 9'd0);
        rep.lvl_b  = {1'b0, r.rd_b} - (sgn_b ? jh8_pkg::SIGNED_OFFSET : 9'd0);
        bin_reports_due.push_back(rep);
      end
      jh8_pkg::KIND_CLEAR: begin
        n_clear++;
        clear_counts();
      end
      default: n_unused++;
    endcase
  endtask

  // Request acceptance and register tracking, sampled at the rising edge.
  pixel_req_t cur_req;
  logic       req_taken = 1'b0;

  always @(posedge clk_i) begin
    req_taken <= s_axis_tvalid && s_axis_tready;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        jh8_pkg::CFG_SIGNED_A: sgn_a = cfg_data_i;
        jh8_pkg::CFG_SIGNED_B: sgn_b = cfg_data_i;
        default: ;
      endcase
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      histogram_update(cur_req);
    end
  end

  // Driver: bursts of requests with random gaps, changed at the falling edge.
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || req_taken) begin
      if (burst_left == 0) begin
        case ($urandom_range(0, 9))
          0: begin
            burst_left = 200;
            gap_left = 0;
          end
          1, 2: begin
            burst_left = $urandom_range(1, 24);
            gap_left = 0;
          end
          default: begin
            burst_left = $urandom_range(1, 24);
            gap_left = $urandom_range(1, 6);
          end
        endcase
      end
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pixel_requests.size() > 0) begin
        cur_req = pixel_requests.pop_front();
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cur_req.kind;
        s_axis_tdata  <= {6'b0, cur_req.rd_b, cur_req.rd_a, cur_req.vb, cur_req.pix_b,
                          cur_req.va, cur_req.pix_a};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Sink stalls follow a 16-bit ready pattern, re-picked among four random kinds.
  logic [15:0] stall_bits = '1;
  int          stall_pos = 0;

  always @(negedge clk_i) begin
    if (stall_pos % 48 == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_bits = '1;
        1:       stall_bits = 16'($urandom);
        2:       stall_bits = 16'($urandom) & 16'($urandom);
        default: stall_bits = 16'($urandom) | 16'($urandom);
      endcase
    end
    m_axis_tready <= stall_bits[stall_pos % 16];
    stall_pos++;
  end

  // Monitor: compare each read result with the oldest report due.
  bin_report_t got, want;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.joint  = m_axis_tdata[31:0];
      got.marg_a = m_axis_tdata[63:32];
      got.marg_b = m_axis_tdata[95:64];
      got.lvl_a  = m_axis_tdata[104:96];
      got.lvl_b  = m_axis_tdata[113:105];
      if (bin_reports_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result joint=%0d a=%0d b=%0d lvl_a=%0d lvl_b=%0d",
                 $realtime, got.joint, got.marg_a, got.marg_b,
                 $signed(got.lvl_a), $signed(got.lvl_b));
      end else begin
        want = bin_reports_due.pop_front();
        n_checked++;
        if (got.joint !== want.joint || got.marg_a !== want.marg_a ||
            got.marg_b !== want.marg_b || got.lvl_a !== want.lvl_a ||
            got.lvl_b !== want.lvl_b) begin
          errors++;
          $display("%0t: mismatch expected joint=%0d a=%0d b=%0d lvl_a=%0d lvl_b=%0d",
                   $realtime, want.joint, want.marg_a, want.marg_b,
                   $signed(want.lvl_a), $signed(want.lvl_b));
          $display("%0t:          actual joint=%0d a=%0d b=%0d lvl_a=%0d lvl_b=%0d",
                   $realtime, got.joint, got.marg_a, got.marg_b,
                   $signed(got.lvl_a), $signed(got.lvl_b));
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d reports still due", $realtime, bin_reports_due.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Request builders.
  task automatic push_req(logic [1:0] k, logic [7:0] pa, logic va, logic [7:0] pb,
                          logic vb, logic [7:0] ra, logic [7:0] rb);
    pixel_req_t r;
    r.kind  = k;
    r.pix_a = pa;
    r.va    = va;
    r.pix_b = pb;
    r.vb    = vb;
    r.rd_a  = ra;
    r.rd_b  = rb;
    pixel_requests.push_back(r);
  endtask

  task automatic push_acc(logic [7:0] pa, logic va, logic [7:0] pb, logic vb);
    push_req(jh8_pkg::KIND_ACC, pa, va, pb, vb, 8'($urandom), 8'($urandom));
  endtask

  task automatic push_read(logic [7:0] ra, logic [7:0] rb);
    push_req(jh8_pkg::KIND_READ, 8'($urandom), 1'($urandom), 8'($urandom),
             1'($urandom), ra, rb);
  endtask

  // Control requests carry random payload so that every data bit toggles.
  task automatic push_ctrl(logic [1:0] k);
    push_req(k, 8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom),
             8'($urandom), 8'($urandom));
  endtask

  // Pixels mostly come from a narrow window so that joint bins collect counts.
  function automatic logic [7:0] hot_pixel();
    return hot_base + 8'($urandom_range(0, 7));
  endfunction

  function automatic logic [7:0] pick_pixel();
    return ($urandom_range(0, 4) == 0) ? 8'($urandom) : hot_pixel();
  endfunction

  // Read bins track the bins the hot pixels land in under this phase's modes.
  task automatic push_hot_read();
    logic [7:0] ra, rb;
    ra = ($urandom_range(0, 3) == 0) ? 8'($urandom)
         : hot_pixel() ^ (gen_sgn_a ? jh8_pkg::SIGN_FLIP : 8'h00);
    rb = ($urandom_range(0, 3) == 0) ? 8'($urandom)
         : hot_pixel() ^ (gen_sgn_b ? jh8_pkg::SIGN_FLIP : 8'h00);
    push_read(ra, rb);
  endtask

  task automatic push_random_phase(int n);
    int clear_at;
    int pick;
    clear_at = $urandom_range(20, n - 20);
    for (int i = 0; i < n - 1; i++) begin
      pick = $urandom_range(0, 99);
      if (i == clear_at) push_ctrl(jh8_pkg::KIND_CLEAR);
      else if (pick < 2) push_ctrl(jh8_pkg::KIND_UNUSED);
      else if (pick < 26) push_hot_read();
      else push_acc(pick_pixel(), $urandom_range(0, 6) != 0,
                    pick_pixel(), $urandom_range(0, 6) != 0);
    end
    // A closing read drains the block before the next register change.
    push_hot_read();
  endtask

  task automatic write_cfg(logic idx, logic val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pixel_requests.size() != 0 || s_axis_tvalid || bin_reports_due.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Stimulus sequence.
  initial begin
    clear_counts();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < N_PHASES; p++) begin
      if (p > 0) wait_idle();
      gen_sgn_a = phase_sgn_a[p];
      gen_sgn_b = phase_sgn_b[p];
      hot_base  = 8'($urandom);
      write_cfg(jh8_pkg::CFG_SIGNED_A, gen_sgn_a);
      write_cfg(jh8_pkg::CFG_SIGNED_B, gen_sgn_b);

      if (p == 0) begin
        // Unsigned extremes, each valid flag combination, unused kind, clear.
        push_acc(8'h00, 1'b1, 8'h00, 1'b1);
        push_acc(8'hFF, 1'b1, 8'hFF, 1'b1);
        push_acc(8'h00, 1'b1, 8'hFF, 1'b1);
        push_acc(8'hFF, 1'b1, 8'h00, 1'b0);
        push_acc(8'h11, 1'b0, 8'h00, 1'b1);
        push_acc(8'h55, 1'b0, 8'hAA, 1'b0);
        push_ctrl(jh8_pkg::KIND_UNUSED);
        push_read(8'h00, 8'h00);
        push_read(8'hFF, 8'hFF);
        push_read(8'h00, 8'hFF);
        push_read(8'hFF, 8'h00);
        push_read(8'h55, 8'hAA);
        push_ctrl(jh8_pkg::KIND_CLEAR);
        push_read(8'h00, 8'h00);
        push_acc(8'h80, 1'b1, 8'h7F, 1'b1);
        push_read(8'h80, 8'h7F);
      end else if (p == 1) begin
        // Signed extremes: -128 lands in bin 0 and +127 in bin 255.
        push_acc(8'h80, 1'b1, 8'h7F, 1'b1);
        push_acc(8'h7F, 1'b1, 8'h80, 1'b1);
        push_acc(8'h00, 1'b1, 8'hFF, 1'b1);
        push_read(8'h00, 8'hFF);
        push_read(8'hFF, 8'h00);
        push_read(8'h80, 8'h7F);
      end
      push_random_phase(RANDOM_ITEMS);
    end

    wait_idle();
    repeat (16) @(posedge clk_i);

    $display("Run covered %0d accumulates, %0d reads, %0d clears, %0d unused requests",
             n_acc, n_read, n_clear, n_unused);
    $display("across %0d signed mode settings; %0d read results checked, %0d errors",
             N_PHASES, n_checked, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
